// ===== src/wrp_pkg.sv =====
// shared types and constants for the weighted random pick block
package wrp_pkg;

	// default configuration
	localparam int MAX_ENTRIES_DEF = 64;
	localparam int WEIGHT_BITS_DEF = 16;

	// fixed field widths
	localparam int ID_W     = 16;
	localparam int IN_WT_W  = 16;
	localparam int RAND_W   = 32;
	localparam int PIDX_W   = 6;

	// batch closing info handed from the front to the back
	typedef struct packed {
		logic              bank;
		logic              overflow;
		logic              prev_valid;
		logic              prev_source;
		logic [ID_W-1:0]   prev_id;
		logic [RAND_W-1:0] rand_word;
	} job_info_t;

	// one pick result
	typedef struct packed {
		logic              found;
		logic              source;
		logic [ID_W-1:0]   id;
		logic [PIDX_W-1:0] index;
		logic              overflow;
	} result_t;

endpackage

// ===== src/wrp_ram.sv =====
// generic single write port, single registered read port ram
module wrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/wrp_front.sv =====
// front end: stores entries of a batch and closes the batch into a job
module wrp_front #(
	parameter int MAX_ENTRIES = wrp_pkg::MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = wrp_pkg::WEIGHT_BITS_DEF,
	localparam int IW = $clog2(MAX_ENTRIES),
	localparam int CW = $clog2(MAX_ENTRIES + 1),
	localparam int EW = WEIGHT_BITS + wrp_pkg::ID_W + 2,
	localparam int AW = IW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          source,
	input  logic [wrp_pkg::ID_W-1:0]      icon_id,
	input  logic [wrp_pkg::IN_WT_W-1:0]   weight,
	input  logic                          enabled,
	input  logic                          last,
	input  logic                          prev_valid,
	input  logic                          prev_source,
	input  logic [wrp_pkg::ID_W-1:0]      prev_id,
	input  logic [wrp_pkg::RAND_W-1:0]    rand_word,
	input  logic                          fifo_full,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [EW-1:0]                 ram_wdata,
	output logic                          push,
	output wrp_pkg::job_info_t            push_info,
	output logic [CW-1:0]                 push_cnt
);

	logic          cnt_lt_max;
	logic          accept;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          bank_q;
	logic [WEIGHT_BITS+wrp_pkg::IN_WT_W-1:0] wt_ext;

	// a request is taken whenever the job queue has room
	assign in_stall   = fifo_full;
	assign accept     = in_valid && !fifo_full;
	assign cnt_lt_max = cnt_q < CW'(MAX_ENTRIES);

	// keep only the low weight bits
	assign wt_ext = {{WEIGHT_BITS{1'b0}}, weight};

	// table write into the bank being filled
	assign ram_we    = accept && cnt_lt_max;
	assign ram_waddr = {bank_q, cnt_q[IW-1:0]};
	assign ram_wdata = {source, icon_id, wt_ext[WEIGHT_BITS-1:0], enabled};

	// job handed to the back on the last entry
	assign push                  = accept && last;
	assign push_cnt              = cnt_lt_max ? cnt_q + CW'(1) : cnt_q;
	assign push_info.bank        = bank_q;
	assign push_info.overflow    = ovf_q || !cnt_lt_max;
	assign push_info.prev_valid  = prev_valid;
	assign push_info.prev_source = prev_source;
	assign push_info.prev_id     = prev_id;
	assign push_info.rand_word   = rand_word;

	// batch fill count, drop flag and bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
				bank_q <= !bank_q;
			end else if (cnt_lt_max) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

// ===== src/wrp_job_fifo.sv =====
// two entry queue of closed batches between front and back
module wrp_job_fifo #(
	parameter int CW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wrp_pkg::job_info_t push_info,
	input  logic [CW-1:0]      push_cnt,
	input  logic               pop,
	output wrp_pkg::job_info_t head_info,
	output logic [CW-1:0]      head_cnt,
	output logic               full,
	output logic               empty
);

	wrp_pkg::job_info_t info_q [2];
	logic [CW-1:0]      cnt_q [2];
	logic               wptr_q;
	logic               rptr_q;
	logic [1:0]         fill_q;

	assign full      = fill_q == 2'd2;
	assign empty     = fill_q == 2'd0;
	assign head_info = info_q[rptr_q];
	assign head_cnt  = cnt_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			info_q[wptr_q] <= push_info;
			cnt_q[wptr_q]  <= push_cnt;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/wrp_back.sv =====
// back end: sum pass, scaled roll and scan pass over one stored batch
module wrp_back #(
	parameter int MAX_ENTRIES = wrp_pkg::MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = wrp_pkg::WEIGHT_BITS_DEF,
	localparam int IW   = $clog2(MAX_ENTRIES),
	localparam int CW   = $clog2(MAX_ENTRIES + 1),
	localparam int EW   = WEIGHT_BITS + wrp_pkg::ID_W + 2,
	localparam int AW   = IW + 1,
	localparam int TOTW = WEIGHT_BITS + CW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avoid_repeat,
	input  logic               fifo_empty,
	input  wrp_pkg::job_info_t head_info,
	input  logic [CW-1:0]      head_cnt,
	output logic               pop,
	output logic               ram_re,
	output logic [AW-1:0]      ram_raddr,
	input  logic [EW-1:0]      ram_rdata,
	output logic               out_valid,
	input  logic               out_stall,
	output wrp_pkg::result_t   out_res
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SUM   = 7'b0000010,
		ST_ROLL1 = 7'b0000100,
		ST_ROLL2 = 7'b0001000,
		ST_ROLL3 = 7'b0010000,
		ST_SCAN  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} back_state_t;

	back_state_t                state_q;
	logic [CW-1:0]              ridx_q;
	logic                       rvld_q;
	logic [IW-1:0]              rpos_q;
	logic [1:0]                 cand_cnt_q;
	logic                       kept_any_q;
	logic [TOTW-1:0]            tot_all_q;
	logic [TOTW-1:0]            tot_kept_q;
	logic                       filt_q;
	logic [TOTW-1:0]            tot_q;
	logic [63:0]                plo_q;
	logic [63:0]                phi_q;
	logic [TOTW-1:0]            roll_q;
	logic [TOTW-1:0]            run_q;
	logic                       hit_q;
	logic                       found_q;
	logic                       psrc_q;
	logic [wrp_pkg::ID_W-1:0]   pid_q;
	logic [IW-1:0]              ppos_q;
	logic                       out_valid_q;
	wrp_pkg::result_t           out_res_q;

	logic                       e_src;
	logic [wrp_pkg::ID_W-1:0]   e_id;
	logic [WEIGHT_BITS-1:0]     e_w;
	logic                       e_en;
	logic                       cand;
	logic                       match;
	logic                       keep;
	logic                       issue;
	logic                       pass_end;
	logic                       out_free;
	logic [TOTW-1:0]            run_next;
	logic [63:0]                tot_ext;
	logic [63:0]                roll_sum;
	logic [IW+wrp_pkg::PIDX_W-1:0] pos_ext;

	// entry decode of the returned table word
	assign e_src = ram_rdata[EW-1];
	assign e_id  = ram_rdata[EW-2 -: wrp_pkg::ID_W];
	assign e_w   = ram_rdata[WEIGHT_BITS:1];
	assign e_en  = ram_rdata[0];
	assign cand  = e_en && (e_w != '0) && (e_id != '0);
	assign match = (e_src == head_info.prev_source) && (e_id == head_info.prev_id);
	assign keep  = cand && !(filt_q && match);

	// table read sequencing for both passes
	assign issue     = ((state_q == ST_SUM) || (state_q == ST_SCAN)) && (ridx_q < head_cnt);
	assign pass_end  = (ridx_q == head_cnt) && !rvld_q;
	assign ram_re    = issue;
	assign ram_raddr = {head_info.bank, ridx_q[IW-1:0]};

	// roll from two 32 by 32 partial products
	assign tot_ext  = 64'(tot_q);
	assign roll_sum = phi_q + {32'b0, plo_q[63:32]};
	assign run_next = run_q + TOTW'(e_w);

	// result handoff
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_DONE) && out_free;
	assign pos_ext  = {{wrp_pkg::PIDX_W{1'b0}}, ppos_q};
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// pass control, accumulators and pick tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ridx_q      <= '0;
			rvld_q      <= 1'b0;
			rpos_q      <= '0;
			cand_cnt_q  <= 2'd0;
			kept_any_q  <= 1'b0;
			tot_all_q   <= '0;
			tot_kept_q  <= '0;
			filt_q      <= 1'b0;
			tot_q       <= '0;
			plo_q       <= '0;
			phi_q       <= '0;
			roll_q      <= '0;
			run_q       <= '0;
			hit_q       <= 1'b0;
			found_q     <= 1'b0;
			psrc_q      <= 1'b0;
			pid_q       <= '0;
			ppos_q      <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			rvld_q <= issue;
			if (issue) begin
				ridx_q <= ridx_q + CW'(1);
				rpos_q <= ridx_q[IW-1:0];
			end
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!fifo_empty) begin
						ridx_q     <= '0;
						cand_cnt_q <= 2'd0;
						kept_any_q <= 1'b0;
						tot_all_q  <= '0;
						tot_kept_q <= '0;
						filt_q     <= 1'b0;
						state_q    <= ST_SUM;
					end
				end
				ST_SUM: begin
					// count candidates and sum both totals in one pass
					if (rvld_q && cand) begin
						cand_cnt_q <= (cand_cnt_q == 2'd2) ? 2'd2 : cand_cnt_q + 2'd1;
						tot_all_q  <= tot_all_q + TOTW'(e_w);
						if (!match) begin
							kept_any_q <= 1'b1;
							tot_kept_q <= tot_kept_q + TOTW'(e_w);
						end
					end
					if (pass_end) begin
						if (avoid_repeat && head_info.prev_valid && (cand_cnt_q == 2'd2)
							&& kept_any_q) begin
							filt_q <= 1'b1;
							tot_q  <= tot_kept_q;
						end else begin
							filt_q <= 1'b0;
							tot_q  <= tot_all_q;
						end
						state_q <= ST_ROLL1;
					end
				end
				ST_ROLL1: begin
					plo_q   <= 64'(head_info.rand_word) * 64'(tot_ext[31:0]);
					state_q <= ST_ROLL2;
				end
				ST_ROLL2: begin
					phi_q   <= 64'(head_info.rand_word) * 64'(tot_ext[63:32]);
					state_q <= ST_ROLL3;
				end
				ST_ROLL3: begin
					roll_q  <= roll_sum[TOTW-1:0];
					ridx_q  <= '0;
					run_q   <= '0;
					hit_q   <= 1'b0;
					found_q <= 1'b0;
					psrc_q  <= 1'b0;
					pid_q   <= '0;
					ppos_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// first kept entry whose running sum passes the roll
					if (rvld_q && keep && !hit_q) begin
						run_q   <= run_next;
						found_q <= 1'b1;
						psrc_q  <= e_src;
						pid_q   <= e_id;
						ppos_q  <= rpos_q;
						if (run_next > roll_q) begin
							hit_q <= 1'b1;
						end
					end
					if (pass_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_res_q.found    <= found_q;
						out_res_q.source   <= psrc_q;
						out_res_q.id       <= pid_q;
						out_res_q.index    <= pos_ext[wrp_pkg::PIDX_W-1:0];
						out_res_q.overflow <= head_info.overflow;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/weighted_random_pick.sv =====
// pick order: with an idle back end a closed batch goes through a sum pass, the roll states
// ROLL1 to ROLL3 and a scan pass over its stored entries before its result is offered
// throughput: one entry per cycle while the job queue has room; batches are picked one
// at a time by the back end, two closed batches can wait in the two table banks
// reset: asynchronous active low, clears fill count, drop flag, queue, avoid_repeat and
// output valid; the entry table is not cleared and needs no clearing pass
module weighted_random_pick #(
	parameter int MAX_ENTRIES = wrp_pkg::MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = wrp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              source,
	input  logic [wrp_pkg::ID_W-1:0]          icon_id,
	input  logic [wrp_pkg::IN_WT_W-1:0]       weight,
	input  logic                              enabled,
	input  logic                              last,
	input  logic                              prev_valid,
	input  logic                              prev_source,
	input  logic [wrp_pkg::ID_W-1:0]          prev_id,
	input  logic [wrp_pkg::RAND_W-1:0]        rand_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic                              pick_source,
	output logic [wrp_pkg::ID_W-1:0]          pick_id,
	output logic [wrp_pkg::PIDX_W-1:0]        pick_index,
	output logic                              overflow
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = WEIGHT_BITS + wrp_pkg::ID_W + 2;
	localparam int AW = IW + 1;

	logic               avoid_q;
	logic               fifo_full;
	logic               fifo_empty;
	logic               push;
	logic               pop;
	wrp_pkg::job_info_t push_info;
	wrp_pkg::job_info_t head_info;
	logic [CW-1:0]      push_cnt;
	logic [CW-1:0]      head_cnt;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [EW-1:0]      ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [EW-1:0]      ram_rdata;
	wrp_pkg::result_t   res;

	// avoid_repeat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avoid_q <= 1'b0;
		end else if (cfg_we) begin
			avoid_q <= cfg_wdata;
		end
	end

	// entry loading
	wrp_front #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.source     (source),
		.icon_id    (icon_id),
		.weight     (weight),
		.enabled    (enabled),
		.last       (last),
		.prev_valid (prev_valid),
		.prev_source(prev_source),
		.prev_id    (prev_id),
		.rand_word  (rand_word),
		.fifo_full  (fifo_full),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.push       (push),
		.push_info  (push_info),
		.push_cnt   (push_cnt)
	);

	// two bank entry table, each bank a power of two deep
	wrp_ram #(
		.WIDTH(EW),
		.DEPTH(2 * (1 << IW))
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// closed batch queue
	wrp_job_fifo #(
		.CW(CW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_info(push_info),
		.push_cnt (push_cnt),
		.pop      (pop),
		.head_info(head_info),
		.head_cnt (head_cnt),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	// pick engine
	wrp_back #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avoid_repeat(avoid_q),
		.fifo_empty  (fifo_empty),
		.head_info   (head_info),
		.head_cnt    (head_cnt),
		.pop         (pop),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_res     (res)
	);

	// result fields
	assign found       = res.found;
	assign pick_source = res.source;
	assign pick_id     = res.id;
	assign pick_index  = res.index;
	assign overflow    = res.overflow;

`ifndef SYNTHESIS
	// a pick always carries a nonzero id
	a_found_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> pick_id != '0)
		else $error("pick with zero id");

	// no pick means cleared pick fields
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> pick_id == '0 && !pick_source && pick_index == '0)
		else $error("pick fields set without a pick");

	// the back only retires a batch that is queued
	a_pop_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_empty)
		else $error("batch retired from empty queue");

	// a full queue holds off new requests
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_full && !pop |=> fifo_full || $past(push) == 1'b0)
		else $error("queue drained without a retire");
`endif

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for weighted_random_pick: predicted picks, idling, back-pressure
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH        = wrp_pkg::MAX_ENTRIES_DEF;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 400000;

	// one request as offered on the input channel
	typedef struct {
		logic                        source;
		logic [wrp_pkg::ID_W-1:0]    icon_id;
		logic [wrp_pkg::IN_WT_W-1:0] weight;
		logic                        enabled;
		logic                        last;
		logic                        prev_valid;
		logic                        prev_source;
		logic [wrp_pkg::ID_W-1:0]    prev_id;
		logic [wrp_pkg::RAND_W-1:0]  rand_word;
	} entry_req_t;

	// entry table mirror, pick prediction and result checking
	class pick_scoreboard;
		logic                        src_tab [DEPTH];
		logic [wrp_pkg::ID_W-1:0]    id_tab  [DEPTH];
		logic [wrp_pkg::IN_WT_W-1:0] wt_tab  [DEPTH];
		logic                        en_tab  [DEPTH];
		int unsigned                 fill;
		bit                          dropped;
		bit                          avoid_repeat;
		int unsigned                 errors;
		wrp_pkg::result_t            pending_picks [$];

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		// candidate test, optionally also rejecting the previous pick
		function bit eligible(int i, bit skip_prev, logic psrc,
				logic [wrp_pkg::ID_W-1:0] pid);
			if (!en_tab[i] || wt_tab[i] == '0 || id_tab[i] == '0)
				return 1'b0;
			if (skip_prev && src_tab[i] == psrc && id_tab[i] == pid)
				return 1'b0;
			return 1'b1;
		endfunction

		// roulette pick over the stored batch
		function wrp_pkg::result_t predict_pick(entry_req_t r);
			int unsigned      cand;
			int unsigned      kept;
			bit               skip_prev;
			logic [63:0]      total;
			logic [63:0]      roll;
			logic [63:0]      run;
			wrp_pkg::result_t p;
			int               i;
			cand  = 0;
			kept  = 0;
			total = '0;
			run   = '0;
			p     = '0;
			for (i = 0; i < fill; i++)
				if (eligible(i, 1'b0, r.prev_source, r.prev_id))
					cand++;
			skip_prev = avoid_repeat && r.prev_valid && cand > 1;
			if (skip_prev) begin
				for (i = 0; i < fill; i++)
					if (eligible(i, 1'b1, r.prev_source, r.prev_id))
						kept++;
				// dropping every candidate is not allowed, keep them all
				if (kept == 0)
					skip_prev = 1'b0;
			end
			for (i = 0; i < fill; i++)
				if (eligible(i, skip_prev, r.prev_source, r.prev_id))
					total += 64'(wt_tab[i]);
			if (total != '0) begin
				roll = ({32'd0, r.rand_word} * total) >> 32;
				for (i = 0; i < fill; i++) begin
					if (eligible(i, skip_prev, r.prev_source, r.prev_id)) begin
						run       += 64'(wt_tab[i]);
						p.found    = 1'b1;
						p.source   = src_tab[i];
						p.id       = id_tab[i];
						p.index    = wrp_pkg::PIDX_W'(i);
						if (run > roll)
							break;
					end
				end
			end
			p.overflow = dropped;
			return p;
		endfunction

		// accepted request: store it, predict on the batch end
		function void take_entry(entry_req_t r);
			if (fill < DEPTH) begin
				src_tab[fill] = r.source;
				id_tab[fill]  = r.icon_id;
				wt_tab[fill]  = r.weight;
				en_tab[fill]  = r.enabled;
				fill++;
			end else begin
				dropped = 1'b1;
			end
			if (r.last) begin
				pending_picks.insert(pending_picks.size(), predict_pick(r));
				fill    = 0;
				dropped = 1'b0;
			end
		endfunction

		// accepted result against the oldest prediction
		task check_pick(wrp_pkg::result_t got);
			wrp_pkg::result_t want;
			if (pending_picks.size() == 0) begin
				report($sformatf("pick with none pending (id %0h)", got.id));
				return;
			end
			want = pending_picks.pop_front();
			if (got.found !== want.found)
				report($sformatf("found %0b, want %0b", got.found, want.found));
			if (got.source !== want.source)
				report($sformatf("pick_source %0b, want %0b", got.source, want.source));
			if (got.id !== want.id)
				report($sformatf("pick_id %0h, want %0h", got.id, want.id));
			if (got.index !== want.index)
				report($sformatf("pick_index %0d, want %0d", got.index, want.index));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
		endtask
	endclass

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_we      = 1'b0;
	logic                        cfg_wdata   = 1'b0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic                        source      = 1'b0;
	logic [wrp_pkg::ID_W-1:0]    icon_id     = '0;
	logic [wrp_pkg::IN_WT_W-1:0] weight      = '0;
	logic                        enabled     = 1'b0;
	logic                        last        = 1'b0;
	logic                        prev_valid  = 1'b0;
	logic                        prev_source = 1'b0;
	logic [wrp_pkg::ID_W-1:0]    prev_id     = '0;
	logic [wrp_pkg::RAND_W-1:0]  rand_word   = '0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic                        found;
	logic                        pick_source;
	logic [wrp_pkg::ID_W-1:0]    pick_id;
	logic [wrp_pkg::PIDX_W-1:0]  pick_index;
	logic                        overflow;

	logic                        quiet       = 1'b0;
	logic                        hold_req    = 1'b0;
	logic                        hold_long   = 1'b0;
	int unsigned                 cycle_count = 0;

	pick_scoreboard sb = new;

	weighted_random_pick dut (.*);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: check accepted picks, draw a stall per pick
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_pick({found, pick_source, pick_id, pick_index, overflow});
				stall_left = quiet ? 0 : $urandom_range(0, 3);
			end
			out_stall <= hold_long || stall_left > 0;
			if (stall_left > 0)
				stall_left--;
		end
	end

	// long receiver hold-off so the block fills and stalls its input
	initial begin : receiver_hold
		wait (hold_req);
		hold_long <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_long <= 1'b0;
	end

	// offer one request after a random gap, wait for acceptance
	task automatic send_entry(entry_req_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		source      <= r.source;
		icon_id     <= r.icon_id;
		weight      <= r.weight;
		enabled     <= r.enabled;
		last        <= r.last;
		prev_valid  <= r.prev_valid;
		prev_source <= r.prev_source;
		prev_id     <= r.prev_id;
		rand_word   <= r.rand_word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_entry(r);
	endtask

	// stop offering, let every pending pick come out, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic set_avoid_repeat(bit on);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= on;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.avoid_repeat = on;
	endtask

	function automatic entry_req_t mk_entry(logic src, logic [wrp_pkg::ID_W-1:0] id,
			logic [wrp_pkg::IN_WT_W-1:0] wt, logic en, logic lst, logic pv, logic ps,
			logic [wrp_pkg::ID_W-1:0] pid, logic [wrp_pkg::RAND_W-1:0] rw);
		entry_req_t r;
		r = '{src, id, wt, en, lst, pv, ps, pid, rw};
		return r;
	endfunction

	// random entry: small id pool for repeats, weights mostly small
	function automatic entry_req_t random_entry();
		entry_req_t r;
		int         sel;
		r.source = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 9);
		if (sel < 7)
			r.icon_id = wrp_pkg::ID_W'($urandom_range(1, 3));
		else if (sel == 7)
			r.icon_id = '0;
		else
			r.icon_id = wrp_pkg::ID_W'($urandom);
		sel = $urandom_range(0, 19);
		if (sel < 12)
			r.weight = wrp_pkg::IN_WT_W'($urandom_range(1, 1024));
		else if (sel < 15)
			r.weight = '0;
		else if (sel < 17)
			r.weight = '1;
		else
			r.weight = wrp_pkg::IN_WT_W'($urandom);
		r.enabled     = ($urandom_range(0, 6) != 0);
		r.last        = 1'b0;
		r.prev_valid  = 1'($urandom_range(0, 1));
		r.prev_source = 1'($urandom_range(0, 1));
		r.prev_id     = wrp_pkg::ID_W'($urandom);
		sel = $urandom_range(0, 9);
		if (sel == 0)
			r.rand_word = '0;
		else if (sel == 1)
			r.rand_word = '1;
		else
			r.rand_word = $urandom;
		return r;
	endfunction

	// one batch; the previous pick is mostly taken from the batch itself
	task automatic run_batch(int size, bit same_key);
		entry_req_t               r;
		logic                     key_src;
		logic [wrp_pkg::ID_W-1:0] key_id;
		logic                     hist_src [$];
		logic [wrp_pkg::ID_W-1:0] hist_id [$];
		int                       n;
		int                       k;
		key_src = 1'($urandom_range(0, 1));
		key_id  = wrp_pkg::ID_W'($urandom_range(1, 3));
		for (n = 0; n < size; n++) begin
			r = random_entry();
			if (same_key) begin
				r.source  = key_src;
				r.icon_id = key_id;
			end
			hist_src.insert(hist_src.size(), r.source);
			hist_id.insert(hist_id.size(), r.icon_id);
			if (n == size - 1) begin
				r.last       = 1'b1;
				r.prev_valid = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 9) < 7) begin
					k = $urandom_range(0, size - 1);
					r.prev_source = hist_src[k];
					r.prev_id     = hist_id[k];
				end
			end
			send_entry(r);
		end
	endtask

	// random batches, mostly short, now and then past the table depth
	task automatic random_phase(int items, bit squeeze);
		int sent;
		int batches;
		int size;
		sent    = 0;
		batches = 0;
		while (sent < items) begin
			if (batches == 0)
				size = $urandom_range(DEPTH + 1, DEPTH + 6);
			else if ($urandom_range(0, 39) == 0)
				size = $urandom_range(DEPTH - 4, DEPTH + 6);
			else
				size = $urandom_range(1, 8);
			if (squeeze && batches == 6)
				hold_req <= 1'b1;
			if (batches % 12 == 11)
				quiet <= ~quiet;
			run_batch(size, $urandom_range(0, 9) == 0);
			sent += size;
			batches++;
		end
	endtask

	// directed batches, run with avoid_repeat set
	task automatic directed_batches();
		// lone entry at the field maxima
		send_entry(mk_entry(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b1, 16'hFFFF,
			32'hFFFF_FFFF));
		// no candidate: empty id, zero weight, disabled
		send_entry(mk_entry(1'b0, 16'h0000, 16'h0005, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b1, 16'h0003, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b0, 16'h0004, 16'h000A, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'h0000,
			32'h8000_0000));
		// previous pick skipped while others remain
		send_entry(mk_entry(1'b0, 16'h0005, 16'h0100, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b1, 16'h0005, 16'h0100, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b0, 16'h0007, 16'h0200, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0005, '0));
		// every candidate equals the previous pick: nothing removed
		send_entry(mk_entry(1'b0, 16'h0009, 16'd100, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b0, 16'h0009, 16'd300, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0009,
			32'hC000_0000));
		// only one candidate and it equals the previous pick
		send_entry(mk_entry(1'b1, 16'h0002, 16'd64, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b1, 16'h0002, 16'd64, 1'b1, 1'b1, 1'b1, 1'b1, 16'h0002,
			32'h1234_5678));
		// previous pick present but flagged invalid
		send_entry(mk_entry(1'b0, 16'h0006, 16'd10, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b0, 16'h0008, 16'd10, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0006, '0));
		// roll at the top and the bottom of the wheel
		send_entry(mk_entry(1'b1, 16'h0001, 16'h0001, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b0, 16'h0002, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b1, 16'h0003, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000,
			32'hFFFF_FFFF));
		send_entry(mk_entry(1'b1, 16'h0001, 16'h0001, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b0, 16'h0002, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, '0));
		send_entry(mk_entry(1'b1, 16'h0003, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, '0));
	endtask

	// reset, then phases at alternating avoid_repeat settings
	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_avoid_repeat(1'b1);
		directed_batches();
		set_avoid_repeat(1'b0);
		random_phase(225, 1'b0);
		set_avoid_repeat(1'b1);
		random_phase(225, 1'b1);
		set_avoid_repeat(1'b0);
		random_phase(225, 1'b0);
		set_avoid_repeat(1'b1);
		random_phase(225, 1'b0);
		wait_drained();
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== weighted_random_pick.f =====
src/wrp_pkg.sv
src/wrp_ram.sv
src/wrp_front.sv
src/wrp_job_fifo.sv
src/wrp_back.sv
src/weighted_random_pick.sv
test/testbench.sv
